/* src/tasms_pkg.sv */
// Shared types and constants for the two-axis stepper move sequencer.
package tasms_pkg;

   // Request action codes
   localparam logic [1:0] ACT_TICK   = 2'd0;
   localparam logic [1:0] ACT_LINEAR = 2'd1;
   localparam logic [1:0] ACT_RAPID  = 2'd2;
   localparam logic [1:0] ACT_HOME   = 2'd3;

   // Configuration register indexes
   localparam logic CSR_FEED_PERIOD  = 1'b0;
   localparam logic CSR_RAPID_PERIOD = 1'b1;

   // Period values after reset
   localparam int FEED_PERIOD_RESET  = 10;
   localparam int RAPID_PERIOD_RESET = 100;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Classified request control, as handed from front to back
   typedef struct packed {
      logic [1:0] action;
      logic       x_rev;
      logic       y_rev;
      logic       x_limit;
      logic       y_limit;
   } cmd_ctl_type;

endpackage

/* src/tasms_front.sv */
// Front stage: takes requests, splits deltas into direction and magnitude.
module tasms_front
   import tasms_pkg::*;
#(
   parameter int MOVE_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_action,
   input  logic signed [MOVE_BITS-1:0] req_delta_x,
   input  logic signed [MOVE_BITS-1:0] req_delta_y,
   input  logic                 req_x_limit,
   input  logic                 req_y_limit,
   output logic                 push_valid,
   input  logic                 push_ready,
   output cmd_ctl_type          push_ctl,
   output logic [MOVE_BITS-1:0] push_x_mag,
   output logic [MOVE_BITS-1:0] push_y_mag
);

   logic                 valid_ff, valid_in;
   cmd_ctl_type          ctl_ff, ctl_in;
   logic [MOVE_BITS-1:0] x_mag_ff, x_mag_in;
   logic [MOVE_BITS-1:0] y_mag_ff, y_mag_in;
   logic                 take;
   logic                 x_neg, y_neg;

   assign req_stall = valid_ff && !push_ready;
   assign take      = req_valid && !req_stall;

   assign x_neg = req_delta_x[MOVE_BITS-1];
   assign y_neg = req_delta_y[MOVE_BITS-1];

   always_comb begin
      ctl_in.action  = req_action;
      ctl_in.x_rev   = x_neg;
      ctl_in.y_rev   = y_neg;
      ctl_in.x_limit = req_x_limit;
      ctl_in.y_limit = req_y_limit;
      // two's complement magnitude; the most negative value maps to 2^(n-1)
      x_mag_in = x_neg ? (~req_delta_x + MOVE_BITS'(1)) : req_delta_x;
      y_mag_in = y_neg ? (~req_delta_y + MOVE_BITS'(1)) : req_delta_y;
      if (take) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         ctl_ff   <= ctl_in;
         x_mag_ff <= x_mag_in;
         y_mag_ff <= y_mag_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_ctl   = ctl_ff;
   assign push_x_mag = x_mag_ff;
   assign push_y_mag = y_mag_ff;

endmodule

/* src/tasms_queue.sv */
// Short request queue between the front and back stages.
module tasms_queue
   import tasms_pkg::*;
#(
   parameter int WIDTH = 38
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0]     slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   assign push_ready = (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_data   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                     : wr_ptr_ff + QPTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                     : rd_ptr_ff + QPTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* src/tasms_back.sv */
// Back stage: motion sequencer state, period registers and result register.
module tasms_back
   import tasms_pkg::*;
#(
   parameter int MOVE_BITS   = 16,
   parameter int PERIOD_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  cmd_ctl_type            pop_ctl,
   input  logic [MOVE_BITS-1:0]   pop_x_mag,
   input  logic [MOVE_BITS-1:0]   pop_y_mag,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [PERIOD_BITS-1:0] csr_wdata,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [3:0]             rsp_x_coils,
   output logic [3:0]             rsp_y_coils,
   output logic                   rsp_busy_res,
   output logic                   rsp_finished,
   output logic                   rsp_rejected
);

   localparam logic [2:0] MODE_IDLE     = 3'd0;
   localparam logic [2:0] MODE_DIAG_X   = 3'd1;
   localparam logic [2:0] MODE_DIAG_Y   = 3'd2;
   localparam logic [2:0] MODE_STRAIGHT = 3'd3;
   localparam logic [2:0] MODE_HOME_X   = 3'd4;
   localparam logic [2:0] MODE_HOME_Y   = 3'd5;

   localparam logic [1:0] PHASE_LAST = 2'd3;

   function automatic logic [3:0] coil_onehot(input logic [1:0] phase, input logic rev);
      logic [1:0] p;
      p = rev ? (PHASE_LAST - phase) : phase;
      coil_onehot = 4'b0001 << p;
   endfunction

   // period registers
   logic [PERIOD_BITS-1:0] feed_ff, rapid_ff;

   // sequencer state
   logic [2:0]             mode_ff, mode_in;
   logic [MOVE_BITS-1:0]   diag_ff, diag_in;
   logic [MOVE_BITS-1:0]   straight_ff, straight_in;
   logic                   str_y_ff, str_y_in;
   logic                   x_rev_ff, x_rev_in;
   logic                   y_rev_ff, y_rev_in;
   logic [1:0]             phase_ff, phase_in;
   logic [PERIOD_BITS-1:0] tick_ff, tick_in;
   logic [PERIOD_BITS-1:0] period_ff, period_in;

   // result register
   logic       out_valid_ff, out_valid_in;
   logic [3:0] x_coils_ff, x_coils_in;
   logic [3:0] y_coils_ff, y_coils_in;
   logic       busy_ff, busy_in;
   logic       fin_ff, fin_in;
   logic       rej_ff, rej_in;

   logic                   take;
   logic                   y_longer;
   logic [MOVE_BITS-1:0]   short_mag, long_rest;
   logic [MOVE_BITS-1:0]   diag_dec, straight_dec;
   logic [PERIOD_BITS-1:0] tick_inc;

   assign pop_ready = !out_valid_ff || !rsp_stall;
   assign take      = pop_valid && pop_ready;
   assign csr_ready = 1'b1;

   // split a move into diagonal units and a straight remainder
   assign y_longer  = (pop_y_mag > pop_x_mag);
   assign short_mag = y_longer ? pop_x_mag : pop_y_mag;
   assign long_rest = y_longer ? (pop_y_mag - pop_x_mag) : (pop_x_mag - pop_y_mag);

   assign diag_dec     = diag_ff - MOVE_BITS'(1);
   assign straight_dec = straight_ff - MOVE_BITS'(1);
   assign tick_inc     = tick_ff + PERIOD_BITS'(1);

   always_comb begin
      mode_in     = mode_ff;
      diag_in     = diag_ff;
      straight_in = straight_ff;
      str_y_in    = str_y_ff;
      x_rev_in    = x_rev_ff;
      y_rev_in    = y_rev_ff;
      phase_in    = phase_ff;
      tick_in     = tick_ff;
      period_in   = period_ff;
      fin_in      = 1'b0;
      rej_in      = 1'b0;

      if (pop_ctl.action != ACT_TICK) begin
         if (mode_ff != MODE_IDLE) begin
            rej_in = 1'b1;
         end else if (pop_ctl.action == ACT_HOME) begin
            period_in   = rapid_ff;
            x_rev_in    = 1'b1;
            y_rev_in    = 1'b1;
            diag_in     = '0;
            straight_in = '0;
            phase_in    = '0;
            tick_in     = '0;
            mode_in     = MODE_HOME_X;
         end else begin
            x_rev_in    = pop_ctl.x_rev;
            y_rev_in    = pop_ctl.y_rev;
            str_y_in    = y_longer;
            diag_in     = short_mag;
            straight_in = long_rest;
            period_in   = (pop_ctl.action == ACT_LINEAR) ? feed_ff : rapid_ff;
            phase_in    = '0;
            tick_in     = '0;
            if (short_mag != '0) begin
               mode_in = MODE_DIAG_X;
            end else if (long_rest != '0) begin
               mode_in = MODE_STRAIGHT;
            end else begin
               mode_in = MODE_IDLE;
               fin_in  = 1'b1;
            end
         end
      end else if (mode_ff != MODE_IDLE) begin
         if (tick_inc >= period_ff) begin
            tick_in = '0;
            if (phase_ff == PHASE_LAST) begin
               // four-phase cycle complete
               phase_in = '0;
               unique case (mode_ff)
                  MODE_DIAG_X: begin
                     mode_in = MODE_DIAG_Y;
                  end
                  MODE_DIAG_Y: begin
                     diag_in = diag_dec;
                     if (diag_dec != '0) begin
                        mode_in = MODE_DIAG_X;
                     end else if (straight_ff != '0) begin
                        mode_in = MODE_STRAIGHT;
                     end else begin
                        mode_in = MODE_IDLE;
                        fin_in  = 1'b1;
                     end
                  end
                  MODE_STRAIGHT: begin
                     straight_in = straight_dec;
                     if (straight_dec == '0) begin
                        mode_in = MODE_IDLE;
                        fin_in  = 1'b1;
                     end
                  end
                  MODE_HOME_X: begin
                     if (!pop_ctl.x_limit) begin
                        mode_in = MODE_HOME_Y;
                     end
                  end
                  MODE_HOME_Y: begin
                     if (!pop_ctl.y_limit) begin
                        mode_in = MODE_IDLE;
                        fin_in  = 1'b1;
                     end
                  end
                  default: begin
                     mode_in = MODE_IDLE;
                     fin_in  = 1'b1;
                  end
               endcase
            end else begin
               phase_in = phase_ff + 2'd1;
            end
         end else begin
            tick_in = tick_inc;
         end
      end

      // coil drive for the state after this request
      x_coils_in = '0;
      y_coils_in = '0;
      unique case (mode_in) inside
         MODE_DIAG_X, MODE_HOME_X: begin
            x_coils_in = coil_onehot(phase_in, x_rev_in);
         end
         MODE_DIAG_Y, MODE_HOME_Y: begin
            y_coils_in = coil_onehot(phase_in, y_rev_in);
         end
         MODE_STRAIGHT: begin
            if (str_y_in) begin
               y_coils_in = coil_onehot(phase_in, y_rev_in);
            end else begin
               x_coils_in = coil_onehot(phase_in, x_rev_in);
            end
         end
         default: begin
         end
      endcase
      busy_in = (mode_in != MODE_IDLE);

      if (take) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         feed_ff      <= PERIOD_BITS'(FEED_PERIOD_RESET);
         rapid_ff     <= PERIOD_BITS'(RAPID_PERIOD_RESET);
         mode_ff      <= MODE_IDLE;
         diag_ff      <= '0;
         straight_ff  <= '0;
         str_y_ff     <= 1'b0;
         x_rev_ff     <= 1'b0;
         y_rev_ff     <= 1'b0;
         phase_ff     <= '0;
         tick_ff      <= '0;
         period_ff    <= PERIOD_BITS'(FEED_PERIOD_RESET);
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_FEED_PERIOD) begin
               feed_ff <= csr_wdata;
            end else begin
               rapid_ff <= csr_wdata;
            end
         end
         if (take) begin
            mode_ff     <= mode_in;
            diag_ff     <= diag_in;
            straight_ff <= straight_in;
            str_y_ff    <= str_y_in;
            x_rev_ff    <= x_rev_in;
            y_rev_ff    <= y_rev_in;
            phase_ff    <= phase_in;
            tick_ff     <= tick_in;
            period_ff   <= period_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         x_coils_ff <= x_coils_in;
         y_coils_ff <= y_coils_in;
         busy_ff    <= busy_in;
         fin_ff     <= fin_in;
         rej_ff     <= rej_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_x_coils  = x_coils_ff;
   assign rsp_y_coils  = y_coils_ff;
   assign rsp_busy_res = busy_ff;
   assign rsp_finished = fin_ff;
   assign rsp_rejected = rej_ff;

`ifndef ASSERT_OFF
   a_one_coil: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ($onehot0({x_coils_ff, y_coils_ff})))
      else $error("more than one coil energized");

   a_idle_no_coil: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !busy_ff) |-> (x_coils_ff == '0 && y_coils_ff == '0))
      else $error("coil driven while idle");

   a_busy_coil: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && busy_ff) |-> (x_coils_ff != '0 || y_coils_ff != '0))
      else $error("busy without a coil");

   a_fin_idle: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && fin_ff) |-> (!busy_ff && !rej_ff))
      else $error("finished while still busy or rejected");

   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_IDLE) |-> (phase_ff == '0 && tick_ff == '0))
      else $error("idle with phase or tick count left over");
`endif

endmodule

/* src/two_axis_stepper_move_sequencer_core.sv */
// Top level of the two-axis stepper move sequencer: front, queue and back.
//
//  channel  prefix  handshake          payload
//  request  req_    valid / stall      action, delta_x, delta_y, x_limit, y_limit
//  result   rsp_    valid / stall      x_coils, y_coils, busy_res, finished, rejected
//  config   csr_    valid / ready      index (0 feed, 1 rapid), wdata
//
//  One request per clock sustained while rsp_stall is low; every request gives exactly one result.
//  A request passes through the front register, a queue slot and the result register.
//  The back stage's state update sets the rate.
//  Synchronous active-high reset: periods 10 / 100, sequencer idle, queue empty.
//  rsp_stall holds the result register; the 2-entry queue and front register
//  keep taking requests until they fill, then req_stall rises.
//  csr_ready is always high; writes belong in idle time.
module two_axis_stepper_move_sequencer_core
   import tasms_pkg::*;
#(
   parameter int MOVE_BITS   = 16,
   parameter int PERIOD_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_action,
   input  logic signed [MOVE_BITS-1:0] req_delta_x,
   input  logic signed [MOVE_BITS-1:0] req_delta_y,
   input  logic                   req_x_limit,
   input  logic                   req_y_limit,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [3:0]             rsp_x_coils,
   output logic [3:0]             rsp_y_coils,
   output logic                   rsp_busy_res,
   output logic                   rsp_finished,
   output logic                   rsp_rejected,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [PERIOD_BITS-1:0] csr_wdata
);

   localparam int ENTRY_BITS = $bits(cmd_ctl_type) + 2 * MOVE_BITS;

   // front -> queue
   logic                 f_valid, f_ready;
   cmd_ctl_type          f_ctl;
   logic [MOVE_BITS-1:0] f_x_mag, f_y_mag;

   // queue -> back
   logic                  q_valid, q_ready;
   logic [ENTRY_BITS-1:0] q_data;
   cmd_ctl_type           q_ctl;
   logic [MOVE_BITS-1:0]  q_x_mag, q_y_mag;

   tasms_front #(
      .MOVE_BITS (MOVE_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_action  (req_action),
      .req_delta_x (req_delta_x),
      .req_delta_y (req_delta_y),
      .req_x_limit (req_x_limit),
      .req_y_limit (req_y_limit),
      .push_valid  (f_valid),
      .push_ready  (f_ready),
      .push_ctl    (f_ctl),
      .push_x_mag  (f_x_mag),
      .push_y_mag  (f_y_mag)
   );

   tasms_queue #(
      .WIDTH (ENTRY_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  ({f_ctl, f_x_mag, f_y_mag}),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   assign {q_ctl, q_x_mag, q_y_mag} = q_data;

   tasms_back #(
      .MOVE_BITS   (MOVE_BITS),
      .PERIOD_BITS (PERIOD_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_valid    (q_valid),
      .pop_ready    (q_ready),
      .pop_ctl      (q_ctl),
      .pop_x_mag    (q_x_mag),
      .pop_y_mag    (q_y_mag),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_x_coils  (rsp_x_coils),
      .rsp_y_coils  (rsp_y_coils),
      .rsp_busy_res (rsp_busy_res),
      .rsp_finished (rsp_finished),
      .rsp_rejected (rsp_rejected)
   );

endmodule
